@@ sv/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk and muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/reef_pkg.sv @@
package reef_pkg;

  // Input commands
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  // Result events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PRESS = 2'd1;
  localparam logic [1:0] EV_FWD   = 2'd2;
  localparam logic [1:0] EV_REV   = 2'd3;

  // Register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_REVERSAL   = 2'd1;
  localparam logic [1:0] CFG_FWD_LEVEL  = 2'd2;
  localparam logic [1:0] CFG_BTN_ACTIVE = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [7:0] DEBOUNCE_RST = 8'd40;
  localparam logic [3:0] REVERSAL_RST = 4'd2;

  localparam logic [3:0] OPP_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [3:0] reversal_count;
    logic       forward_level;
    logic       button_active_level;
  } cfg_t;

endpackage

@@ sv/reef_if.sv @@
interface reef_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       dir_level;
  logic       button_level;

  modport source (output valid, cmd, dir_level, button_level, input ready);
  modport sink   (input valid, cmd, dir_level, button_level, output ready);
endinterface

interface reef_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;

  modport source (output valid, event_res, input ready);
  modport sink   (input valid, event_res, output ready);
endinterface

@@ sv/reef_cfg_regs.sv @@
module reef_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [reef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [reef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output reef_pkg::cfg_t                  cfg
);
  import reef_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEBOUNCE_RST;
      cfg_r.reversal_count      <= REVERSAL_RST;
      cfg_r.forward_level       <= 1'b1;
      cfg_r.button_active_level <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE:   cfg_r.debounce_ticks      <= cfg_wdata;
        CFG_REVERSAL:   cfg_r.reversal_count      <= cfg_wdata[3:0];
        CFG_FWD_LEVEL:  cfg_r.forward_level       <= cfg_wdata[0];
        CFG_BTN_ACTIVE: cfg_r.button_active_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/reef_core.sv @@
module reef_core (
  input  logic           clk,
  input  logic           rst_n,
  input  reef_pkg::cfg_t cfg,
  input  logic           adv,
  input  logic [1:0]     cmd,
  input  logic           dir_level,
  input  logic           button_level,
  output logic [1:0]     event_res
);
  import reef_pkg::*;

  logic [7:0] lockout_r,  lockout_nxt;
  logic [1:0] pend_r,     pend_nxt;
  logic       last_dir_r, last_dir_nxt;
  logic [3:0] opp_r,      opp_nxt;
  logic       last_btn_r, last_btn_nxt;

  logic       dir;
  logic [3:0] opp_inc;
  logic       press;

  always_comb begin
    dir     = (dir_level != cfg.forward_level);
    opp_inc = (opp_r < OPP_MAX) ? opp_r + 4'd1 : OPP_MAX;
    press   = (last_btn_r != button_level) && (button_level == cfg.button_active_level);

    lockout_nxt  = lockout_r;
    pend_nxt     = pend_r;
    last_dir_nxt = last_dir_r;
    opp_nxt      = opp_r;
    last_btn_nxt = last_btn_r;
    event_res    = press ? EV_PRESS : pend_r;

    if (adv) begin
      case (cmd)
        CMD_TICK: begin
          if (lockout_r != 8'd0) lockout_nxt = lockout_r - 8'd1;
        end
        CMD_EDGE: begin
          if (lockout_r == 8'd0) begin
            lockout_nxt = cfg.debounce_ticks;
            pend_nxt    = dir ? EV_REV : EV_FWD;
            if (dir == last_dir_r) begin
              opp_nxt = 4'd0;
            end else if (opp_inc < cfg.reversal_count) begin
              // reversal not yet confirmed: drop any pending spin
              opp_nxt  = opp_inc;
              pend_nxt = EV_NONE;
            end else begin
              last_dir_nxt = dir;
              opp_nxt      = 4'd0;
            end
          end
        end
        CMD_POLL: begin
          last_btn_nxt = button_level;
          if (!press) pend_nxt = EV_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r  <= 8'd0;
      pend_r     <= EV_NONE;
      last_dir_r <= 1'b0;
      opp_r      <= 4'd0;
      last_btn_r <= 1'b0;
    end else begin
      lockout_r  <= lockout_nxt;
      pend_r     <= pend_nxt;
      last_dir_r <= last_dir_nxt;
      opp_r      <= opp_nxt;
      last_btn_r <= last_btn_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_tick_dec, adv && cmd == CMD_TICK && lockout_r != 8'd0,
               lockout_r == $past(lockout_r) - 8'd1, "lockout did not count down")
  `ASSERT_NEXT(a_locked_edge, adv && cmd == CMD_EDGE && lockout_r != 8'd0,
               $stable(pend_r) && $stable(opp_r) && $stable(last_dir_r),
               "edge during lockout changed state")
  `ASSERT_IMPL(a_opp_range, 1'b1, opp_r != OPP_MAX, "opposite count reached saturation")

endmodule

@@ sv/reef_out_reg.sv @@
module reef_out_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [1:0] event_res,
  output logic       space,
  reef_out_if.source out_ch
);

  logic       valid_r;
  logic [1:0] data_r;

  assign space = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= event_res;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.event_res = data_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_load_valid, load, valid_r, "loaded result not presented")
  `ASSERT_IMPL(a_no_overrun, load, space, "result register overwritten while held")

endmodule

@@ sv/rotary_encoder_event_filter.sv @@
// Rotary encoder event filter.
// in_ch carries one transaction per item: cmd (tick, clock falling edge or
// poll) with the direction and button pin levels. out_ch carries one
// transaction, event_res, for every poll and nothing for ticks and edges.
// cfg_we/cfg_idx/cfg_wdata write the debounce length, reversal count,
// forward level and button active level; write only while the block idles.
// An item waits in the input register; when it advances, the filter state
// and the result register update together, so a poll result is presented
// from the result register. One item per cycle is taken unless a poll is
// held back by a full result register; results are taken back to back too.
// When out_ch stalls with a result held, non-poll items keep flowing and a
// following poll waits in the input register, which drops in_ch.ready.
// Synchronous reset (rst_n low) empties both registers, clears the lockout,
// pending spin, opposite count and button history, sets the direction to
// forward and restores the register defaults.
module rotary_encoder_event_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [reef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [reef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  reef_in_if.sink                         in_ch,
  reef_out_if.source                      out_ch
);
  import reef_pkg::*;

  cfg_t       cfg;
  logic       v_r;
  logic [1:0] cmd_r;
  logic       dir_r;
  logic       btn_r;
  logic       space;
  logic       adv;
  logic       load;
  logic [1:0] event_res;

  assign adv         = v_r && (cmd_r != CMD_POLL || space);
  assign load        = adv && cmd_r == CMD_POLL;
  assign in_ch.ready = !v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.cmd;
      dir_r <= in_ch.dir_level;
      btn_r <= in_ch.button_level;
    end
  end

  reef_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  reef_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .adv          (adv),
    .cmd          (cmd_r),
    .dir_level    (dir_r),
    .button_level (btn_r),
    .event_res    (event_res)
  );

  reef_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .event_res (event_res),
    .space     (space),
    .out_ch    (out_ch)
  );

endmodule
